// ===== rtl/core/lrut_pkg.sv =====
package lrut_pkg;

  localparam int DEF_WAYS = 32;
  localparam int DEF_SETS = 1;

  localparam int TAG_W     = 32;
  localparam int STAMP_W   = 64;
  localparam int COUNT_W   = 64;
  localparam int WAY_OUT_W = 5;
  // ways and sets both top out at 64
  localparam int WAY_IDX_W = 6;
  localparam int SET_IDX_W = 6;

  localparam int IN_W  = 32;
  localparam int OUT_W = 136;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // search token handed from way to way
  typedef struct packed {
    logic                 found;
    logic [WAY_IDX_W-1:0] way;
    logic [STAMP_W-1:0]   stamp;
  } token_t;

  localparam token_t TOK_INIT = '{found: 1'b0, way: '0, stamp: '1};

  typedef struct packed {
    logic                 rd_en;
    logic                 clr;
    logic                 wr_en;
    logic [WAY_IDX_W-1:0] wr_way;
    logic [SET_IDX_W-1:0] set;
    logic [TAG_W-1:0]     tag;
    entry_t               entry;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ===== rtl/core/lru_tag_lookup_table.sv =====
// LRU tag lookup table: set-associative tag store with least-recently-used
// replacement, one way per cell in a row of cells.
// Input channel s_*: one item is a 32-bit handle tag. Output channel m_*:
// one result item per input item (hit flag, way, running hit/miss counts).
// Per item: the accept cycle, a set remainder step when SETS is not a
// power of two, a memory read, the walk of the search token along the
// row of cells (one cell per cycle), and a write; with the defaults the
// token walk takes most of an item's time. The result sits in an output
// register, so a new item is accepted while it waits to be taken.
// If the receiver stalls with a result still held, the next item finishes
// its search and waits in the write cycle until the register frees.
// Reset: stamp clock to one, counters to zero, then a clearing pass over
// every set zeroes every entry; s_tready stays low during it.
module lru_tag_lookup_table #(
  parameter int WAYS = lrut_pkg::DEF_WAYS,
  parameter int SETS = lrut_pkg::DEF_SETS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [31:0] handle_tag
  input  logic [lrut_pkg::IN_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [0] hit, [5:1] way_used, [69:6] hit_count, [133:70] miss_count,
  // [135:134] zero
  output logic [lrut_pkg::OUT_W-1:0] m_tdata
);
  import lrut_pkg::*;

  localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  SCAN_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam logic [SET_W:0] SETS_C = (SET_W + 1)'(SETS);

  state_t state, state_next;

  logic [SET_W-1:0]   clr_idx;
  logic [TAG_W-1:0]   tag_q;
  logic [TAG_W-1:0]   mod_sh;
  logic [2:0]         mod_cnt;
  logic [SET_W-1:0]   set_q;
  logic [SET_W-1:0]   mod_next;
  logic [SCAN_W-1:0]  scan_cnt;
  logic [STAMP_W-1:0] stamp_clock;
  logic [COUNT_W-1:0] hits_total;
  logic [COUNT_W-1:0] misses_total;

  logic                 out_hit;
  logic [WAY_OUT_W-1:0] out_way;
  logic [COUNT_W-1:0]   out_hits;
  logic [COUNT_W-1:0]   out_misses;

  logic      out_free;
  logic      do_write;
  logic      accept;
  cell_ctl_t ctl;
  token_t    tok [WAYS];
  token_t    res;

  assign out_free = !m_tvalid || m_tready;
  assign do_write = (state == ST_WRITE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign res      = tok[WAYS-1];

  // ---- cell row: token enters at way 0 and moves one way per cycle ----
  assign ctl.rd_en       = (state == ST_READ);
  assign ctl.clr         = (state == ST_CLEAR);
  assign ctl.wr_en       = do_write;
  assign ctl.wr_way      = res.way;
  assign ctl.set         = (state == ST_CLEAR) ? SET_IDX_W'(clr_idx) : SET_IDX_W'(set_q);
  assign ctl.tag         = tag_q;
  assign ctl.entry.valid = 1'b1;
  assign ctl.entry.tag   = tag_q;
  assign ctl.entry.stamp = stamp_clock;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    lrut_cell #(
      .SETS (SETS),
      .IDX  (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .tok_in  ((i == 0) ? TOK_INIT : tok[(i == 0) ? 0 : i-1]),
      .tok_out (tok[i])
    );
  end

  // ---- set remainder, four tag bits a cycle, MSB first ----
  always_comb begin
    logic [SET_W:0] r;
    r = {1'b0, set_q};
    for (int k = 0; k < 4; k++) begin
      r = {r[SET_W-1:0], mod_sh[TAG_W-1-k]};
      if (r >= SETS_C) begin
        r = r - SETS_C;
      end
    end
    mod_next = r[SET_W-1:0];
  end

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = SETS_POW2 ? ST_READ : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_cnt == 3'd7) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_W'(WAYS - 1)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // ---- datapath and counters ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      stamp_clock  <= STAMP_W'(1);
      hits_total   <= '0;
      misses_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (do_write) begin
        stamp_clock <= stamp_clock + 1'b1;
        if (res.found) begin
          hits_total <= hits_total + 1'b1;
        end else begin
          misses_total <= misses_total + 1'b1;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q   <= s_tdata[TAG_W-1:0];
      mod_sh  <= s_tdata[TAG_W-1:0];
      mod_cnt <= '0;
      set_q   <= (SETS == 1) ? '0 : (SETS_POW2 ? s_tdata[SET_W-1:0] : '0);
    end else if (state == ST_MOD) begin
      mod_sh  <= mod_sh << 4;
      mod_cnt <= mod_cnt + 1'b1;
      set_q   <= mod_next;
    end
    if (state == ST_READ) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (do_write) begin
      out_hit    <= res.found;
      out_way    <= res.way[WAY_OUT_W-1:0];
      out_hits   <= res.found ? hits_total + 1'b1 : hits_total;
      out_misses <= res.found ? misses_total : misses_total + 1'b1;
    end
  end

  assign m_tdata = {2'b00, out_misses, out_hits, out_way, out_hit};

`ifndef ASSERT_OFF
  // each finished item bumps exactly one of the two counters
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (hits_total + misses_total) ==
                 ($past(hits_total) + $past(misses_total) + 1'b1))
    else $error("hit/miss counters did not advance by one");

  // the stamp clock moves only when an entry is written
  a_stamp_hold: assert property (@(posedge clk) disable iff (rst)
    !do_write |=> $stable(stamp_clock))
    else $error("stamp clock moved without an entry write");

  // a new result only comes out of the write cycle
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_WRITE)
    else $error("result raised outside the write cycle");

  // nothing is accepted until the clearing pass is done
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !($past(accept)))
    else $error("item accepted during the clearing pass");
`endif

endmodule

// ===== rtl/core/lrut_cell.sv =====
module lrut_cell #(
  parameter int SETS = lrut_pkg::DEF_SETS,
  parameter int IDX  = 0
) (
  input  logic                clk,
  input  lrut_pkg::cell_ctl_t ctl,
  input  lrut_pkg::token_t    tok_in,
  output lrut_pkg::token_t    tok_out
);
  import lrut_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  entry_t mem [SETS];
  entry_t entry_q;
  token_t tok_next;
  logic   wr;

  assign wr = ctl.clr || (ctl.wr_en && (ctl.wr_way == WAY_IDX_W'(IDX)));

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[ctl.set[SET_W-1:0]] <= ctl.clr ? entry_t'('0) : ctl.entry;
    end
    if (ctl.rd_en) begin
      entry_q <= mem[ctl.set[SET_W-1:0]];
    end
  end

  // first valid match wins; otherwise keep the strictly older stamp
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found) begin
      if (entry_q.valid && (entry_q.tag == ctl.tag)) begin
        tok_next.found = 1'b1;
        tok_next.way   = WAY_IDX_W'(IDX);
      end else if (entry_q.stamp < tok_in.stamp) begin
        tok_next.stamp = entry_q.stamp;
        tok_next.way   = WAY_IDX_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrut_pkg::*;

  localparam int WAYS        = DEF_WAYS;
  localparam int SETS        = DEF_SETS;
  localparam int DRAIN_TAIL  = 3 * WAYS + 16;
  // ~760 items, each worst case: block cycles, the longest sender gap and
  // output stall, plus the one long hold-off; taken about five times over
  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 400;

  // one result item as it sits in m_tdata[133:0], hit in bit 0
  typedef struct packed {
    logic [COUNT_W-1:0]   misses;
    logic [COUNT_W-1:0]   hits;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } lookup_res_t;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_BURSTY} rx_mode_t;

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // [31:0] handle_tag
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // [0] hit, [5:1] way_used, [69:6] hit_count, [133:70] miss_count, [135:134] zero
  logic [OUT_W-1:0]  m_tdata;

  lru_tag_lookup_table #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the tag table, used to predict each lookup
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0]   shadow_tag   [SETS][WAYS] = '{default: '0};
  bit                 shadow_valid [SETS][WAYS] = '{default: 1'b0};
  logic [STAMP_W-1:0] shadow_stamp [SETS][WAYS] = '{default: '0};
  // clock starts at one so empty ways (stamp zero) always win the LRU victim search
  logic [STAMP_W-1:0] use_clock   = STAMP_W'(1);
  logic [COUNT_W-1:0] hits_seen   = '0;
  logic [COUNT_W-1:0] misses_seen = '0;

  lookup_res_t        lookups_due [$];
  logic [TAG_W-1:0]   tag_pool    [$];

  int       errors        = 0;
  int       items_sent    = 0;
  int       results_seen  = 0;
  int       tx_burst_left = 0;
  bit       tx_gaps       = 1'b0;
  rx_mode_t rx_mode       = RX_OPEN;
  int       rx_hold_len   = 0;
  int       in_stall_cyc  = 0;

  function automatic lookup_res_t predict_lookup(input logic [TAG_W-1:0] tag);
    int unsigned set_idx;
    int          victim;
    int          chosen;
    bit          found;
    lookup_res_t res;
    set_idx = tag % SETS;
    victim  = 0;
    chosen  = 0;
    found   = 1'b0;
    // first matching valid way wins; LRU candidate tracked on the way past
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
        found  = 1'b1;
        chosen = w;
        break;
      end
      if (shadow_stamp[set_idx][w] < shadow_stamp[set_idx][victim]) victim = w;
    end
    if (found) begin
      hits_seen = hits_seen + 1'b1;
    end else begin
      misses_seen = misses_seen + 1'b1;
      chosen      = victim;
    end
    shadow_valid[set_idx][chosen] = 1'b1;
    shadow_tag[set_idx][chosen]   = tag;
    shadow_stamp[set_idx][chosen] = use_clock;
    use_clock = use_clock + 1'b1;
    res.hit    = found;
    res.way    = chosen[WAY_OUT_W-1:0];
    res.hits   = hits_seen;
    res.misses = misses_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles, %0d lookups outstanding",
             CYCLE_LIMIT, lookups_due.size());
    $display("FAIL lru_tag_lookup_table");
    $finish;
  end

  // counts cycles where the block refuses a waiting input item
  always @(posedge clk) begin
    if (!rst && s_tvalid && !s_tready) in_stall_cyc++;
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        m_tready <= 1'b0;
        rx_hold_len--;
      end else begin
        case (rx_mode)
          RX_OPEN: begin
            m_tready <= 1'b1;
          end
          RX_CHOPPY: begin
            m_tready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            // stretches of stall of random length
            if (stall_left > 0) begin
              m_tready <= 1'b0;
              stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(1, 60);
              m_tready <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result item against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    lookup_res_t want;
    lookup_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(lookup_res_t)-1:0];
      results_seen++;
      if (lookups_due.size() == 0) begin
        $error("result item with no lookup outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = lookups_due.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.way !== want.way) begin
          $error("way_used: expected %0d, got %0d", want.way, got.way);
          errors++;
        end
        if (got.hits !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, got.hits);
          errors++;
        end
        if (got.misses !== want.misses) begin
          $error("miss_count: expected %0d, got %0d", want.misses, got.misses);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Leaves tvalid high after the accept so that a back-to-back call keeps it
  // up; anything that lets time pass afterwards must call stop_sending first.
  task automatic send_handle(input logic [TAG_W-1:0] tag);
    lookup_res_t due;
    if (tx_gaps && tx_burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 16);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= tag;
    do @(posedge clk); while (!s_tready);
    due = predict_lookup(tag);
    lookups_due.push_back(due);
    items_sent++;
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
    tx_burst_left = 0;
  endtask

  task automatic wait_all_results();
    while (lookups_due.size() != 0) @(posedge clk);
  endtask

  task automatic refill_pool(input int n);
    tag_pool.delete();
    repeat (n) tag_pool.push_back($urandom());
  endtask

  function automatic logic [TAG_W-1:0] pool_tag();
    return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the tag and the empty table: a zero tag must miss while the
  // ways are empty (zero tag but not valid), empty ways fill lowest first.
  task automatic test_directed();
    logic [TAG_W-1:0] seq [] = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                                 32'hAAAA_AAAA, 32'h0000_0001, 32'hAAAA_AAAA,
                                 32'h0000_0000, 32'h7FFF_FFFF};
    tx_gaps = 1'b0;
    rx_mode = RX_OPEN;
    foreach (seq[i]) send_handle(seq[i]);
    stop_sending();
  endtask

  // Working set smaller than the table: mostly hits once warmed up.
  task automatic test_hot_set();
    tx_gaps = 1'b1;
    rx_mode = RX_CHOPPY;
    refill_pool(WAYS * 2 / 3);
    repeat (120) send_handle(pool_tag());
    stop_sending();
  endtask

  // Fill every way with fresh tags, touch some of them, then bring in new
  // tags: each must evict the least recently used way. A cyclic sweep over
  // one tag more than the ways misses every time under LRU.
  task automatic test_lru_eviction();
    logic [TAG_W-1:0] fresh [$];
    tx_gaps = 1'b1;
    rx_mode = RX_BURSTY;
    repeat (3) begin
      fresh.delete();
      repeat (WAYS) fresh.push_back($urandom());
      foreach (fresh[i]) send_handle(fresh[i]);
      repeat (WAYS / 2) send_handle(fresh[$urandom_range(0, WAYS - 1)]);
      repeat (WAYS / 2) send_handle($urandom());
    end
    fresh.delete();
    repeat (WAYS + 1) fresh.push_back($urandom());
    repeat (2) foreach (fresh[i]) send_handle(fresh[i]);
    stop_sending();
  endtask

  // Receiver holds off long enough for the output register and the write
  // stage to fill, so the block has to stall its input.
  task automatic test_output_backpressure();
    tx_gaps     = 1'b0;
    rx_mode     = RX_OPEN;
    rx_hold_len = HOLD_CYCLES;
    refill_pool(8);
    repeat (30) send_handle(($urandom_range(0, 1) != 0) ? pool_tag() : $urandom());
    stop_sending();
  endtask

  // Sender pauses until every result is back, then carries on.
  task automatic test_drain_pause();
    tx_gaps = 1'b1;
    rx_mode = RX_CHOPPY;
    refill_pool(12);
    repeat (10) send_handle(pool_tag());
    stop_sending();
    wait_all_results();
    repeat (10) send_handle(pool_tag());
    stop_sending();
  endtask

  // Mix: reused tags (hits and evictions), fully random tags, walking-one and
  // walking-zero tags; receiver and sender idling change along the way.
  task automatic test_mixed_traffic();
    int               pick;
    logic [TAG_W-1:0] tag;
    refill_pool(WAYS + 8);
    for (int n = 0; n < 320; n++) begin
      if (n % 80 == 0) begin
        tx_gaps = (n != 160);
        rx_mode = rx_mode_t'($urandom_range(0, 2));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        tag = pool_tag();
      end else if (pick < 85) begin
        tag = $urandom();
      end else begin
        tag = 32'h1 << $urandom_range(0, TAG_W - 1);
        if ($urandom_range(0, 1) != 0) tag = ~tag;
      end
      send_handle(tag);
    end
    stop_sending();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_hot_set();
    test_lru_eviction();
    test_output_backpressure();
    test_drain_pause();
    test_mixed_traffic();

    wait_all_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d lookups (%0d hits, %0d misses), %0d results checked;",
             items_sent, hits_seen, misses_seen, results_seen);
    $display("covered empty-way fill, LRU eviction sweeps, %0d input stall cycles",
             in_stall_cyc);
    if (errors == 0 && lookups_due.size() == 0) begin
      $display("PASS lru_tag_lookup_table");
    end else begin
      $display("FAIL lru_tag_lookup_table");
    end
    $finish;
  end

endmodule

// ===== lru_tag_lookup_table.f =====
rtl/core/lrut_pkg.sv
rtl/core/lrut_cell.sv
rtl/core/lru_tag_lookup_table.sv
tb/tb_top.sv
